@@ rtl/bhts_pkg.sv @@
// Shared types, constants and helper functions for the bucketed hash table store.
// Used by the top level, the controller and the datapath; no dependencies of its own.
package bhts_pkg;

  // Default sizing.
  localparam int BUCKET_COUNT_DEF    = 128;
  localparam int WAYS_PER_BUCKET_DEF = 4;

  // Field widths of the words on both channels.
  localparam int KEY_W    = 64;
  localparam int WORD_W   = 64;
  localparam int STATUS_W = 3;

  // Request kinds.
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;

  // Controller to datapath.
  typedef struct packed {
    logic accept;      // latch request, read fill count
    logic scan_start;  // latch fill count, read way 0
    logic hit_latch;   // key matched at current way
    logic next_way;    // advance to next way, read it
    logic commit;      // write back and load result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic used_zero;   // bucket empty
    logic key_match;   // key read back equals request key
    logic last_way;    // current way is the last one in use
    logic out_free;    // result register can take a word this cycle
  } stat_t;

  // First key byte to bucket index: counts up and wraps at the bucket count,
  // evaluated at elaboration so the hardware is a constant lookup.
  function automatic logic [255:0][7:0] bucket_lut(int count);
    logic [255:0][7:0] lut;
    int                rem;
    rem = 0;
    for (int v = 0; v < 256; v++) begin
      lut[v] = 8'(rem);
      rem++;
      if (rem == count) begin
        rem = 0;
      end
    end
    return lut;
  endfunction

endpackage

@@ rtl/bucketed_hash_table_store_unit.sv @@
// Top level of the bucketed hash table store: controller plus datapath.
// Depends on bhts_pkg, bhts_ctrl, bhts_dp (and bhts_ram through it).
//
//   channel | direction | handshake             | word fields
//   --------+-----------+-----------------------+------------------------------------
//   in      | to block  | in_valid_i/in_stall_o | kind_i, lookup_key_i, data_word_i
//   out     | from block| out_valid_o/out_stall_i| status_code_o, read_word_o
//
// Sequence: each request reads its bucket fill count, then compares the ways in
//   use (none for an empty bucket, up to WAYS_PER_BUCKET); the key RAM is single
//   ported and is scanned one way per cycle.
// Reset: asynchronous, active low. Fill counts read as zero through one valid
//   bit per bucket, so there is no clearing pass; key/word RAMs need no reset.
// Stalls: the result sits in an output register. A new request is taken while
//   it waits; the next result waits in its last state until that register frees.
// Bucket = first key byte (unsigned) modulo BUCKET_COUNT, via a constant table.
module bucketed_hash_table_store_unit #(
  parameter int BUCKET_COUNT    = bhts_pkg::BUCKET_COUNT_DEF,
  parameter int WAYS_PER_BUCKET = bhts_pkg::WAYS_PER_BUCKET_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [bhts_pkg::KEY_W-1:0]    lookup_key_i,
  input  logic [bhts_pkg::WORD_W-1:0]   data_word_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bhts_pkg::STATUS_W-1:0] status_code_o,
  output logic [bhts_pkg::WORD_W-1:0]   read_word_o
);

  bhts_pkg::cmd_t  cmd;
  bhts_pkg::stat_t stat;

  // Sequencer: idle -> fill count -> way scan -> write back / result.
  bhts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage, compare and result register.
  bhts_dp #(
    .BUCKET_COUNT    (BUCKET_COUNT),
    .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .lookup_key_i  (lookup_key_i),
    .data_word_i   (data_word_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .status_code_o (status_code_o),
    .read_word_o   (read_word_o)
  );

endmodule

@@ rtl/bhts_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module bhts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bhts_ctrl.sv @@
// Sequencing state machine for the bucketed hash table store.
// Depends on bhts_pkg (command and status structs).
module bhts_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bhts_pkg::stat_t stat_i,
  output bhts_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_COUNT  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd_o.scan_start = 1'b1;
        state_d          = stat_i.used_zero ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        priority if (stat_i.key_match) begin
          cmd_o.hit_latch = 1'b1;
          state_d         = S_FINISH;
        end else if (stat_i.last_way) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.next_way = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

@@ rtl/bhts_dp.sv @@
// Datapath: request registers, bucket fill RAM with valid bits, key and word RAMs,
// way scan registers and the result register. Depends on bhts_pkg and bhts_ram.
module bhts_dp #(
  parameter int BUCKET_COUNT    = bhts_pkg::BUCKET_COUNT_DEF,
  parameter int WAYS_PER_BUCKET = bhts_pkg::WAYS_PER_BUCKET_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          kind_i,
  input  logic [bhts_pkg::KEY_W-1:0]    lookup_key_i,
  input  logic [bhts_pkg::WORD_W-1:0]   data_word_i,
  input  logic                          out_stall_i,
  input  bhts_pkg::cmd_t                cmd_i,
  output bhts_pkg::stat_t               stat_o,
  output logic                          out_valid_o,
  output logic [bhts_pkg::STATUS_W-1:0] status_code_o,
  output logic [bhts_pkg::WORD_W-1:0]   read_word_o
);

  localparam int BUCKET_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int WAY_W    = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
  localparam int FILL_W   = $clog2(WAYS_PER_BUCKET + 1);
  localparam int SLOTS    = BUCKET_COUNT * WAYS_PER_BUCKET;
  localparam int ADDR_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [255:0][7:0] BUCKET_LUT = bhts_pkg::bucket_lut(BUCKET_COUNT);

  // Request
  logic                        kind_q;
  logic [bhts_pkg::KEY_W-1:0]  key_q;
  logic [bhts_pkg::WORD_W-1:0] word_q;
  logic [BUCKET_W-1:0]         bucket_q, bucket_d;

  // Scan
  logic [FILL_W-1:0]           used_q, used_now;
  logic [WAY_W-1:0]            way_q;
  logic                        hit_q;
  logic [bhts_pkg::WORD_W-1:0] hit_word_q;

  // Per-bucket valid bits stand in for a cleared fill count
  logic [BUCKET_COUNT-1:0]     bkt_valid_q, bkt_valid_d;

  // Result register
  logic                          out_valid_q, out_valid_d;
  logic [bhts_pkg::STATUS_W-1:0] out_status_q, status_d;
  logic [bhts_pkg::WORD_W-1:0]   out_word_q, word_res_d;

  // RAM ports
  logic [FILL_W-1:0]           fill_rdata;
  logic [bhts_pkg::KEY_W-1:0]  key_rdata;
  logic [bhts_pkg::WORD_W-1:0] word_rdata;
  logic [FILL_W-1:0]           way_sel;
  logic [ADDR_W-1:0]           slot_addr;
  logic                        is_store, full, do_insert, do_update;

  assign bucket_d = BUCKET_LUT[lookup_key_i[7:0]][BUCKET_W-1:0];

  assign used_now = bkt_valid_q[bucket_q] ? fill_rdata : '0;

  assign is_store  = (kind_q == bhts_pkg::KIND_STORE);
  assign full      = (used_q == FILL_W'(WAYS_PER_BUCKET));
  assign do_insert = cmd_i.commit && is_store && !hit_q && !full;
  assign do_update = cmd_i.commit && is_store && hit_q;

  always_comb begin
    priority if (cmd_i.scan_start) begin
      way_sel = '0;
    end else if (cmd_i.next_way) begin
      way_sel = FILL_W'(way_q) + 1'b1;
    end else if (hit_q) begin
      way_sel = FILL_W'(way_q);
    end else begin
      way_sel = used_q;
    end
  end

  assign slot_addr = ADDR_W'(bucket_q) * ADDR_W'(WAYS_PER_BUCKET) + ADDR_W'(way_sel);

  bhts_ram #(
    .WIDTH (FILL_W),
    .DEPTH (BUCKET_COUNT)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .en_i    (cmd_i.accept || do_insert),
    .we_i    (do_insert),
    .addr_i  (cmd_i.accept ? bucket_d : bucket_q),
    .wdata_i (used_q + 1'b1),
    .rdata_o (fill_rdata)
  );

  bhts_ram #(
    .WIDTH (bhts_pkg::KEY_W),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .en_i    (cmd_i.scan_start || cmd_i.next_way || do_insert),
    .we_i    (do_insert),
    .addr_i  (slot_addr),
    .wdata_i (key_q),
    .rdata_o (key_rdata)
  );

  bhts_ram #(
    .WIDTH (bhts_pkg::WORD_W),
    .DEPTH (SLOTS)
  ) u_word_ram (
    .clk_i   (clk_i),
    .en_i    (cmd_i.scan_start || cmd_i.next_way || do_insert || do_update),
    .we_i    (do_insert || do_update),
    .addr_i  (slot_addr),
    .wdata_i (word_q),
    .rdata_o (word_rdata)
  );

  always_comb begin
    priority if (!is_store) begin
      status_d = hit_q ? bhts_pkg::ST_FOUND : bhts_pkg::ST_MISSING;
    end else if (hit_q) begin
      status_d = bhts_pkg::ST_UPDATED;
    end else if (full) begin
      status_d = bhts_pkg::ST_FULL;
    end else begin
      status_d = bhts_pkg::ST_INSERTED;
    end
  end

  assign word_res_d = (!is_store && hit_q) ? hit_word_q : '0;

  always_comb begin
    bkt_valid_d = bkt_valid_q;
    if (do_insert) begin
      bkt_valid_d[bucket_q] = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bkt_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bkt_valid_q <= bkt_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q   <= kind_i;
      key_q    <= lookup_key_i;
      word_q   <= data_word_i;
      bucket_q <= bucket_d;
    end
    if (cmd_i.scan_start) begin
      used_q <= used_now;
      way_q  <= '0;
      hit_q  <= 1'b0;
    end
    if (cmd_i.next_way) begin
      way_q <= way_q + 1'b1;
    end
    if (cmd_i.hit_latch) begin
      hit_q      <= 1'b1;
      hit_word_q <= word_rdata;
    end
    if (cmd_i.commit) begin
      out_status_q <= status_d;
      out_word_q   <= word_res_d;
    end
  end

  assign stat_o.used_zero = (used_now == '0);
  assign stat_o.key_match = (key_rdata == key_q);
  assign stat_o.last_way  = ((FILL_W'(way_q) + 1'b1) == used_q);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_code_o = out_status_q;
  assign read_word_o   = out_word_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for bucketed_hash_table_store_unit.
// Depends on bhts_pkg and the block's RTL; it keeps its own copy of the
// table state and checks every result word in order.
module testbench;

  localparam int BUCKETS     = bhts_pkg::BUCKET_COUNT_DEF;
  localparam int WAYS        = bhts_pkg::WAYS_PER_BUCKET_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int POOL_SIZE   = 16;

  typedef struct packed {
    logic [bhts_pkg::STATUS_W-1:0] status;
    logic [bhts_pkg::WORD_W-1:0]   word;
  } outcome_t;

  // DUT ports, all known from time zero
  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_stall_o;
  logic                          kind_i       = bhts_pkg::KIND_STORE;
  logic [bhts_pkg::KEY_W-1:0]    lookup_key_i = '0;
  logic [bhts_pkg::WORD_W-1:0]   data_word_i  = '0;
  logic                          out_valid_o;
  logic                          out_stall_i  = 1'b0;
  logic [bhts_pkg::STATUS_W-1:0] status_code_o;
  logic [bhts_pkg::WORD_W-1:0]   read_word_o;

  // Shadow of the table: fill count per bucket, keys and words per way
  int                          fill_model [BUCKETS];
  logic [bhts_pkg::KEY_W-1:0]  key_model  [BUCKETS][WAYS];
  logic [bhts_pkg::WORD_W-1:0] word_model [BUCKETS][WAYS];

  outcome_t                   pending_outcomes[$];
  logic [bhts_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  int   error_count   = 0;
  int   cycle_count   = 0;
  int   burst_left    = 0;
  int   gap_max       = 0;    // 0 = sender never idles
  logic long_hold_req = 1'b0; // asks the receiver for one long hold-off

  bucketed_hash_table_store_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .lookup_key_i  (lookup_key_i),
    .data_word_i   (data_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_code_o (status_code_o),
    .read_word_o   (read_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_outcomes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Predicts the result of one request and updates the shadow table.
  // Bucket uses the first key byte as unsigned, so 0x80..0xFF alias 0x00..0x7F.
  function automatic outcome_t hash_store_outcome(
      input logic                        kind,
      input logic [bhts_pkg::KEY_W-1:0]  key,
      input logic [bhts_pkg::WORD_W-1:0] word);
    int       bkt;
    int       way;
    outcome_t res;
    bkt = int'(key[7:0]) % BUCKETS;
    way = -1;
    res.status = bhts_pkg::ST_MISSING;
    res.word   = '0;
    // only ways in use are compared, so unwritten entries are never looked at
    for (int w = 0; w < fill_model[bkt]; w++) begin
      if (way < 0 && key_model[bkt][w] == key) begin
        way = w;
      end
    end
    if (kind == bhts_pkg::KIND_STORE) begin
      if (way >= 0) begin
        word_model[bkt][way] = word;
        res.status = bhts_pkg::ST_UPDATED;
      end else if (fill_model[bkt] >= WAYS) begin
        res.status = bhts_pkg::ST_FULL;   // rejected, nothing written
      end else begin
        key_model[bkt][fill_model[bkt]]  = key;
        word_model[bkt][fill_model[bkt]] = word;
        fill_model[bkt]++;
        res.status = bhts_pkg::ST_INSERTED;
      end
    end else if (way >= 0) begin
      res.status = bhts_pkg::ST_FOUND;
      res.word   = word_model[bkt][way];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  // Sends one request word. Gaps are only inserted between bursts; valid is
  // left high on return so back-to-back words keep it asserted.
  task automatic send_word(input logic kind, input logic [bhts_pkg::KEY_W-1:0] key,
                           input logic [bhts_pkg::WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    lookup_key_i <= key;
    data_word_i  <= word;
    // handshake values are sampled before the edge updates them
    do @(posedge clk_i); while (in_stall_o);
    pending_outcomes.push_back(hash_store_outcome(kind, key, word));
  endtask

  // Sender pause: wait until every expected result word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Result checker plus receiver stall pattern. Stall runs in modes of random
  // length: never, light, heavy, and a fixed 3-of-8 rhythm; a long hold-off
  // is counted here on request.
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;
  int rhythm     = 0;

  always @(posedge clk_i) begin
    outcome_t want;
    logic     stall_next;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("word with nothing expected", read_word_o, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (status_code_o !== want.status) begin
          report_mismatch("status_code", 64'(status_code_o), 64'(want.status));
        end
        if (read_word_o !== want.word) begin
          report_mismatch("read_word", read_word_o, want.word);
        end
      end
    end

    if (long_hold_req) begin
      hold_left = 400;
      long_hold_req <= 1'b0;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    rhythm = (rhythm + 1) % 8;
    case (stall_mode)
      0: stall_next = 1'b0;
      1: stall_next = ($urandom_range(0, 3) == 0);
      2: stall_next = ($urandom_range(0, 3) != 0);
      default: stall_next = (rhythm < 3);
    endcase
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end
    out_stall_i <= stall_next;
  end

  // Edge cases: empty key, bucket aliasing of the high first-byte values,
  // bucket overflow, update in place, full-width key compare, fetch ignoring
  // the data field.
  task automatic test_corner_keys();
    gap_max = 2;
    send_word(bhts_pkg::KIND_FETCH, 64'h0, 64'hDEAD_BEEF_0000_0001);  // empty bucket
    send_word(bhts_pkg::KIND_STORE, 64'h0, '1);                        // empty key
    send_word(bhts_pkg::KIND_FETCH, 64'h0, 64'h0);
    send_word(bhts_pkg::KIND_STORE, 64'h80, 64'h0123_4567_89AB_CDEF);  // aliases to 0
    send_word(bhts_pkg::KIND_STORE, 64'hFFFF_FFFF_FFFF_FF00, 64'h0);
    send_word(bhts_pkg::KIND_STORE, 64'h0, 64'h0);                     // update
    send_word(bhts_pkg::KIND_STORE, 64'h100, 64'h8000_0000_0000_0000); // bucket full now
    send_word(bhts_pkg::KIND_STORE, 64'h200, 64'h1);                   // rejected
    send_word(bhts_pkg::KIND_FETCH, 64'h200, '1);
    send_word(bhts_pkg::KIND_FETCH, 64'h80, 64'h0);
    send_word(bhts_pkg::KIND_FETCH, 64'h8000_0000_0000_0000, 64'h0);   // one high bit
    send_word(bhts_pkg::KIND_FETCH, 64'hFFFF_FFFF_FFFF_FF00, 64'h0);
    send_word(bhts_pkg::KIND_FETCH, '1, 64'h0);                        // bucket 0x7F
    send_word(bhts_pkg::KIND_STORE, '1, 64'h5555_5555_5555_5555);
    send_word(bhts_pkg::KIND_STORE, 64'h7F, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(bhts_pkg::KIND_FETCH, 64'h7F, '1);
    send_word(bhts_pkg::KIND_FETCH, '1, 64'h0);
    send_word(bhts_pkg::KIND_STORE, '1, '1);                           // update to ones
    send_word(bhts_pkg::KIND_FETCH, '1, 64'h0);
    send_word(bhts_pkg::KIND_FETCH, 64'h100, 64'h0);
    drain_results();
  endtask

  function automatic logic [bhts_pkg::KEY_W-1:0] random_key(input logic [7:0] first_byte);
    logic [bhts_pkg::KEY_W-1:0] key;
    int                         len;
    key = {$urandom, $urandom};
    len = $urandom_range(1, 8);
    if (len < 8) begin
      key = key & ((64'h1 << (8 * len)) - 1);   // short zero-padded string
    end
    key[7:0] = first_byte;
    return key;
  endfunction

  function automatic logic [bhts_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly a small pool of keys over a few buckets, so stores hit updates and
  // full buckets and fetches mostly hit; the rest are fresh random keys.
  task automatic test_random_mix(input int phases, input int per_phase);
    logic [7:0]                 bucket_bytes [4];
    logic                       kind;
    logic [bhts_pkg::KEY_W-1:0] key;
    int                         gap_settings [8] = '{0, 3, 12, 0, 6, 20, 1, 8};
    for (int p = 0; p < phases; p++) begin
      gap_max = gap_settings[p % 8];
      foreach (bucket_bytes[i]) bucket_bytes[i] = 8'($urandom);
      foreach (key_pool[i]) key_pool[i] = random_key(bucket_bytes[$urandom_range(0, 3)]);
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 99) < 75) begin
          key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
          kind = ($urandom_range(0, 1) == 0) ? bhts_pkg::KIND_STORE : bhts_pkg::KIND_FETCH;
        end else begin
          key  = random_key(8'($urandom));
          kind = ($urandom_range(0, 9) < 3) ? bhts_pkg::KIND_STORE : bhts_pkg::KIND_FETCH;
        end
        send_word(kind, key, random_word());
      end
      drain_results();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // words back to back, so the block fills up and stalls its input.
  task automatic test_backpressure_fill();
    gap_max = 0;
    @(posedge clk_i);
    long_hold_req <= 1'b1;
    for (int n = 0; n < 60; n++) begin
      send_word(($urandom_range(0, 1) == 0) ? bhts_pkg::KIND_STORE : bhts_pkg::KIND_FETCH,
                key_pool[$urandom_range(0, POOL_SIZE - 1)], random_word());
    end
    drain_results();
  endtask

  initial begin
    foreach (fill_model[i]) fill_model[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_keys();
    test_random_mix(4, 200);
    test_backpressure_fill();
    test_random_mix(4, 200);

    drain_results();
    if (pending_outcomes.size() != 0) begin
      report_mismatch("words never arrived", 64'(pending_outcomes.size()), '0);
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ bucketed_hash_table_store_unit.f @@
rtl/bhts_pkg.sv
rtl/bhts_ram.sv
rtl/bhts_ctrl.sv
rtl/bhts_dp.sv
rtl/bucketed_hash_table_store_unit.sv
sim/testbench.sv
